// ===== sv/sapg_pkg.sv =====
// ----------------------------------------------------------------------------
// sapg_pkg
// shared types and constants of the servo angle pulse generator
// ----------------------------------------------------------------------------
package sapg_pkg;

  localparam int WIDTH_BITS_DEF  = 12;
  localparam int ANGLE_BITS      = 17;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int REG_IDX_BITS    = 3;

  // reset values of the configuration registers
  localparam int CENTER_RESET  = 1640;
  localparam int MIN_END_RESET = 2240;
  localparam int MAX_END_RESET = 1040;
  localparam logic signed [ANGLE_BITS-1:0] ANGLE_LIMIT_RESET =
    ANGLE_BITS'(45 << ANGLE_FRAC_BITS);

  typedef enum logic [1:0] {
    REQ_ANGLE  = 2'd0,
    REQ_WIDTH  = 2'd1,
    REQ_PERIOD = 2'd2,
    REQ_TICK   = 2'd3
  } req_type_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_CENTER    = 3'd0,
    REG_MIN_END   = 3'd1,
    REG_MAX_END   = 3'd2,
    REG_MIN_ANGLE = 3'd3,
    REG_MAX_ANGLE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic start;
  } seq_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_sts_t;

endpackage

// ===== sv/sapg_if.sv =====
// ----------------------------------------------------------------------------
// sapg_if
// request and response channels of the servo angle pulse generator
// ----------------------------------------------------------------------------
interface sapg_req_if #(
  parameter int WIDTH_BITS = sapg_pkg::WIDTH_BITS_DEF
) ();
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             req_type;
  logic signed [sapg_pkg::ANGLE_BITS-1:0] angle;
  logic [WIDTH_BITS-1:0]                  width;

  modport source (output valid, req_type, angle, width, input ready);
  modport sink   (input valid, req_type, angle, width, output ready);
endinterface

interface sapg_rsp_if #(
  parameter int WIDTH_BITS = sapg_pkg::WIDTH_BITS_DEF
) ();
  logic                                   valid;
  logic                                   ready;
  logic                                   pin_level;
  logic [WIDTH_BITS-1:0]                  commanded_width;
  logic signed [sapg_pkg::ANGLE_BITS-1:0] set_angle;

  modport source (output valid, pin_level, commanded_width, set_angle, input ready);
  modport sink   (input valid, pin_level, commanded_width, set_angle, output ready);
endinterface

// ===== sv/servo_angle_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// servo_angle_pulse_generator
// servo pulse width from angle or width commands, one pulse per period start
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   valid/ready          req_type, angle, width
//  rsp      out  valid/ready          pin_level, commanded_width, set_angle
//  cfg      in   cfg_we               cfg_idx, cfg_data
//
//  angle command: the response follows the multiply, load, divide and fix steps
//  of the angle map; the restoring divider yields one quotient bit a cycle and
//  is skipped when the selected angle limit is zero.
//  width, period and tick requests: response the cycle after acceptance.
//  one request in flight; req.ready stays low until its response is taken or
//  is being taken. reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module servo_angle_pulse_generator #(
  parameter int  WIDTH_BITS = sapg_pkg::WIDTH_BITS_DEF,
  localparam int CFG_W = (WIDTH_BITS > sapg_pkg::ANGLE_BITS) ? WIDTH_BITS
                                                             : sapg_pkg::ANGLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  sapg_req_if.sink                            req,
  sapg_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [sapg_pkg::REG_IDX_BITS-1:0]   cfg_idx,
  input  logic [CFG_W-1:0]                    cfg_data
);

  localparam int AB = sapg_pkg::ANGLE_BITS;

  typedef enum logic {
    T_IDLE,
    T_ANGLE
  } top_state_t;

  top_state_t state;

  logic [WIDTH_BITS-1:0] center_width;
  logic [WIDTH_BITS-1:0] min_end_width;
  logic [WIDTH_BITS-1:0] max_end_width;
  logic signed [AB-1:0]  min_angle;
  logic signed [AB-1:0]  max_angle;

  logic [WIDTH_BITS-1:0] target_width;
  logic signed [AB-1:0]  held_angle;
  logic [WIDTH_BITS-1:0] latched_width;
  logic [WIDTH_BITS-1:0] elapsed_us;
  logic                  pin;
  logic                  rsp_valid;
  logic                  rsp_valid_next;

  logic                  req_fire;
  logic                  ends_equal;
  logic signed [AB-1:0]  angle_clamped;
  logic [WIDTH_BITS-1:0] width_clamped;
  logic [WIDTH_BITS-1:0] lo;
  logic [WIDTH_BITS-1:0] hi;
  logic [WIDTH_BITS-1:0] elapsed_next;

  sapg_pkg::seq_ctl_t    map_ctl;
  sapg_pkg::seq_sts_t    map_sts;
  logic [WIDTH_BITS-1:0] map_width;

  assign req.ready = (state == T_IDLE) && (!rsp_valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;

  // pending response stays until taken; a new one comes from a short request
  // or from the end of an angle computation
  assign rsp_valid_next = (rsp_valid && !rsp.ready) ||
                          (req_fire && (req.req_type != sapg_pkg::REQ_ANGLE)) ||
                          ((state == T_ANGLE) && map_sts.done);

  assign ends_equal = (min_end_width == max_end_width);
  assign lo = (min_end_width < max_end_width) ? min_end_width : max_end_width;
  assign hi = (min_end_width < max_end_width) ? max_end_width : min_end_width;

  // with swapped angle limits, angles below the lower limit take it, all others the upper
  always_comb begin
    if (req.angle < min_angle) begin
      angle_clamped = min_angle;
    end else if (req.angle > max_angle) begin
      angle_clamped = max_angle;
    end else begin
      angle_clamped = req.angle;
    end
    if (req.width < lo) begin
      width_clamped = lo;
    end else if (req.width > hi) begin
      width_clamped = hi;
    end else begin
      width_clamped = req.width;
    end
  end

  assign elapsed_next = (elapsed_us == '1) ? elapsed_us : elapsed_us + 1'b1;

  assign map_ctl.start = req_fire && (req.req_type == sapg_pkg::REQ_ANGLE);

  sapg_angle_map #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_map (
    .clk           (clk),
    .rst           (rst),
    .ctl           (map_ctl),
    .angle         (angle_clamped),
    .center_width  (center_width),
    .min_end_width (min_end_width),
    .max_end_width (max_end_width),
    .min_angle     (min_angle),
    .max_angle     (max_angle),
    .sts           (map_sts),
    .result        (map_width)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      center_width  <= WIDTH_BITS'(sapg_pkg::CENTER_RESET);
      min_end_width <= WIDTH_BITS'(sapg_pkg::MIN_END_RESET);
      max_end_width <= WIDTH_BITS'(sapg_pkg::MAX_END_RESET);
      min_angle     <= -sapg_pkg::ANGLE_LIMIT_RESET;
      max_angle     <= sapg_pkg::ANGLE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        sapg_pkg::REG_CENTER:    center_width  <= cfg_data[WIDTH_BITS-1:0];
        sapg_pkg::REG_MIN_END:   min_end_width <= cfg_data[WIDTH_BITS-1:0];
        sapg_pkg::REG_MAX_END:   max_end_width <= cfg_data[WIDTH_BITS-1:0];
        sapg_pkg::REG_MIN_ANGLE: min_angle     <= $signed(cfg_data[AB-1:0]);
        sapg_pkg::REG_MAX_ANGLE: max_angle     <= $signed(cfg_data[AB-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      target_width  <= WIDTH_BITS'(sapg_pkg::CENTER_RESET);
      held_angle    <= '0;
      latched_width <= '0;
      elapsed_us    <= '0;
      pin           <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
      case (state)
        T_IDLE: begin
          if (req_fire) begin
            case (req.req_type)
              sapg_pkg::REQ_ANGLE: begin
                held_angle <= angle_clamped;
                state      <= T_ANGLE;
              end
              sapg_pkg::REQ_WIDTH: begin
                if (!ends_equal) begin
                  target_width <= width_clamped;
                end
              end
              sapg_pkg::REQ_PERIOD: begin
                pin           <= 1'b1;
                latched_width <= target_width;
                elapsed_us    <= '0;
              end
              sapg_pkg::REQ_TICK: begin
                if (pin) begin
                  elapsed_us <= elapsed_next;
                  if (elapsed_next >= latched_width) begin
                    pin <= 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        T_ANGLE: begin
          if (map_sts.done) begin
            if (!ends_equal) begin
              target_width <= map_width;
            end
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // response fields come straight from the state, held until the next transaction
  assign rsp.valid           = rsp_valid;
  assign rsp.pin_level       = pin;
  assign rsp.commanded_width = target_width;
  assign rsp.set_angle       = held_angle;

  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    state == T_ANGLE |-> !req.ready)
    else $error("request accepted during an angle computation");

  a_pin_rise : assert property (@(posedge clk) disable iff (rst)
    $rose(pin) |-> $past(req.valid && req.ready &&
                         req.req_type == sapg_pkg::REQ_PERIOD))
    else $error("pin rose without a period start");

  a_map_done_rsp : assert property (@(posedge clk) disable iff (rst)
    map_sts.done |=> rsp.valid)
    else $error("angle result not presented");

  a_map_idle : assert property (@(posedge clk) disable iff (rst)
    state == T_IDLE |-> !map_sts.busy)
    else $error("angle map running while idle");

endmodule

// ===== sv/sapg_divider.sv =====
// ----------------------------------------------------------------------------
// sapg_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sapg_divider #(
  parameter int NUM_W = sapg_pkg::WIDTH_BITS_DEF + 16,
  parameter int DEN_W = sapg_pkg::ANGLE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  sapg_pkg::seq_ctl_t ctl,
  input  logic [NUM_W-1:0]   dividend,
  input  logic [DEN_W-1:0]   divisor,
  output sapg_pkg::seq_sts_t sts,
  output logic [NUM_W-1:0]   quotient,
  output logic [DEN_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign rem_next = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign quotient  = quo;
  assign remainder = rem;

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> busy && cnt == CNT_W'(NUM_W))
    else $error("divider did not load on start");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a running division");

  a_busy_count : assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("divider running with an empty step count");

endmodule

// ===== sv/sapg_angle_map.sv =====
// ----------------------------------------------------------------------------
// sapg_angle_map
// maps a clamped angle to a pulse width through a restoring divider
// ----------------------------------------------------------------------------
module sapg_angle_map #(
  parameter int WIDTH_BITS = sapg_pkg::WIDTH_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sapg_pkg::seq_ctl_t                     ctl,
  input  logic signed [sapg_pkg::ANGLE_BITS-1:0] angle,
  input  logic [WIDTH_BITS-1:0]                  center_width,
  input  logic [WIDTH_BITS-1:0]                  min_end_width,
  input  logic [WIDTH_BITS-1:0]                  max_end_width,
  input  logic signed [sapg_pkg::ANGLE_BITS-1:0] min_angle,
  input  logic signed [sapg_pkg::ANGLE_BITS-1:0] max_angle,
  output sapg_pkg::seq_sts_t                     sts,
  output logic [WIDTH_BITS-1:0]                  result
);

  localparam int AB = sapg_pkg::ANGLE_BITS;
  localparam int PW = WIDTH_BITS + 1 + AB;   // signed product
  localparam int NW = WIDTH_BITS + 16;       // product magnitude
  localparam int VW = WIDTH_BITS + 18;       // center plus quotient

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL,
    M_LOAD,
    M_WAIT,
    M_FIX
  } map_state_t;

  map_state_t state;

  logic signed [WIDTH_BITS:0] diff;
  logic signed [AB-1:0]       ang;
  logic signed [AB:0]         den;
  logic signed [PW-1:0]       prod;
  logic                       done;

  logic signed [PW-1:0] prod_abs;
  logic signed [AB:0]   den_abs;
  logic                 den_zero;
  logic [WIDTH_BITS-1:0] lo;
  logic [WIDTH_BITS-1:0] hi;

  sapg_pkg::seq_ctl_t div_ctl;
  sapg_pkg::seq_sts_t div_sts;
  logic [NW-1:0]      div_quo;
  logic [AB:0]        div_rem;

  logic signed [VW-1:0] q_mag;
  logic signed [VW-1:0] q_val;
  logic signed [VW-1:0] v_sum;
  logic signed [VW-1:0] lo_v;
  logic signed [VW-1:0] hi_v;
  logic [WIDTH_BITS-1:0] fix_width;

  assign prod_abs = prod[PW-1] ? -prod : prod;
  assign den_abs  = den[AB] ? -den : den;
  assign den_zero = (den == '0);
  assign lo = (min_end_width < max_end_width) ? min_end_width : max_end_width;
  assign hi = (min_end_width < max_end_width) ? max_end_width : min_end_width;

  assign div_ctl.start = (state == M_LOAD) && !den_zero;

  sapg_divider #(
    .NUM_W (NW),
    .DEN_W (AB + 1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (prod_abs[NW-1:0]),
    .divisor   (den_abs),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // floor of the signed quotient, then add center and clamp to the end widths
  always_comb begin
    q_mag = $signed({(VW-NW)'(0), div_quo});
    if ((prod[PW-1] ^ den[AB]) && (prod != '0)) begin
      q_val = -(q_mag + VW'(div_rem != '0));
    end else begin
      q_val = q_mag;
    end
    v_sum = $signed({(VW-WIDTH_BITS)'(0), center_width}) + q_val;
    lo_v  = $signed({(VW-WIDTH_BITS)'(0), lo});
    hi_v  = $signed({(VW-WIDTH_BITS)'(0), hi});
    if (den_zero) begin
      // zero divisor saturates toward the sign of the product, or gives center for a zero product
      if (prod == '0) begin
        v_sum = $signed({(VW-WIDTH_BITS)'(0), center_width});
      end else if (prod[PW-1]) begin
        v_sum = lo_v;
      end else begin
        v_sum = hi_v;
      end
    end
    if (v_sum < lo_v) begin
      fix_width = lo;
    end else if (v_sum > hi_v) begin
      fix_width = hi;
    end else begin
      fix_width = v_sum[WIDTH_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (ctl.start) begin
            state <= M_MUL;
          end
        end
        M_MUL: begin
          state <= M_LOAD;
        end
        M_LOAD: begin
          state <= den_zero ? M_FIX : M_WAIT;
        end
        M_WAIT: begin
          if (div_sts.done) begin
            state <= M_FIX;
          end
        end
        M_FIX: begin
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == M_IDLE && ctl.start) begin
      ang <= angle;
      if (angle > 0) begin
        diff <= $signed({1'b0, center_width}) - $signed({1'b0, min_end_width});
        den  <= -$signed({min_angle[AB-1], min_angle});
      end else if (angle < 0) begin
        diff <= $signed({1'b0, max_end_width}) - $signed({1'b0, center_width});
        den  <= $signed({max_angle[AB-1], max_angle});
      end else begin
        diff <= '0;
        den  <= (AB+1)'(1);
      end
    end
    if (state == M_MUL) begin
      prod <= diff * ang;
    end
    if (state == M_FIX) begin
      result <= fix_width;
    end
  end

  assign sts.busy = (state != M_IDLE);
  assign sts.done = done;

  a_result_in_range : assert property (@(posedge clk) disable iff (rst)
    done |-> result >= lo && result <= hi)
    else $error("mapped width outside the end widths");

  a_done_from_fix : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == M_FIX))
    else $error("map done without a final step");

  a_div_only_waiting : assert property (@(posedge clk) disable iff (rst)
    div_sts.busy |-> state == M_WAIT)
    else $error("divider running outside the wait step");

endmodule
